[hw/rtl/char_lcd_nibble_sequencer_assert.svh]
// Assertion macros used by the character LCD sequencer front end.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LCDNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdns: implication check failed");
`define LCDNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdns: next-cycle check failed");
`else
`define LCDNS_ASSERT_IMP(lbl, ante, cons)
`define LCDNS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/lcdns_pkg.sv]
// Types and constants shared by the character LCD sequencer modules.
package lcdns_pkg;

  // Byte queue (entry: bit 8 marks a mode marker, bit 0 of a marker is rs)
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int ENTRY_W    = 9;

  // Job queue between front and back
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_LW    = $clog2(JQ_DEPTH + 2);

  // Input kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;
  localparam logic [1:0] KIND_GOTO = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_INIT  = 2'd0;
  localparam logic [1:0] REG_DISP  = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;

  // Job types
  localparam int JT_W = 3;
  localparam logic [JT_W-1:0] JOB_CLR    = 3'd0;  // startup tick without pulse
  localparam logic [JT_W-1:0] JOB_ONE    = 3'd1;  // one command nibble (high)
  localparam logic [JT_W-1:0] JOB_REPEAT = 3'd2;  // repeat latched nibble
  localparam logic [JT_W-1:0] JOB_TWO    = 3'd3;  // command high then low nibble
  localparam logic [JT_W-1:0] JOB_DRAIN  = 3'd4;  // one queue entry

  typedef struct packed {
    logic [JT_W-1:0]    jtype;
    logic [ENTRY_W-1:0] data;
  } job_t;

endpackage

[hw/rtl/char_lcd_nibble_sequencer.sv]
// Top level of the character LCD 4-bit nibble sequencer.
// Each input word is a tick, a command byte, a character byte or a cursor goto. Bytes
// go into a 32-entry queue held in a RAM (entries are not cleared after reset, so there
// is no clearing pass). A byte whose kind differs from the previous one needs two RAM
// writes (mode marker, then byte), so in_tready stays low while the byte is written;
// every other word is taken without that hold while the job queue has room. A tick that
// sends a full byte gives two nibble words, one per cycle through the output register
// while the receiver takes them. A tick passes through the staging register and the
// job queue before its first nibble is set in the output register.
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] value, [9:8] line, [15:10] zero
  input  logic [1:0]  in_tuser,    // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [3:0] nibble, [7:4] zero
  output logic        out_tuser,   // [0] rs
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import lcdns_pkg::*;

  logic             jq_push, jq_pop;
  job_t             jq_in, jq_head;
  logic [JQ_LW-1:0] jq_level;
  logic [3:0]       nibble;

  lcdns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata[9:0]),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .jq_level  (jq_level),
    .jq_push   (jq_push),
    .jq_job    (jq_in)
  );

  lcdns_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (jq_push),
    .job_in (jq_in),
    .pop    (jq_pop),
    .head   (jq_head),
    .level  (jq_level)
  );

  lcdns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (jq_head),
    .level      (jq_level),
    .pop        (jq_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_nibble (nibble),
    .out_rs     (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'd0, nibble};

endmodule

[hw/rtl/lcdns_ram.sv]
// Generic single-port-write, registered-read RAM.
module lcdns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[hw/rtl/lcdns_front.sv]
// Front end: accepts words, keeps the byte queue and startup state, issues jobs.
`include "char_lcd_nibble_sequencer_assert.svh"
module lcdns_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [9:0]                   in_tdata,
  input  logic [1:0]                   in_tuser,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [7:0]                   cfg_wdata,
  input  logic [lcdns_pkg::JQ_LW-1:0]  jq_level,
  output logic                         jq_push,
  output lcdns_pkg::job_t              jq_job
);
  import lcdns_pkg::*;

  localparam logic [7:0] STEP_WAKE  = 8'd12;
  localparam logic [7:0] STEP_REP_A = 8'd5;
  localparam logic [7:0] STEP_REP_B = 8'd4;
  localparam logic [7:0] STEP_FS1   = 8'd3;
  localparam logic [7:0] STEP_FS2   = 8'd2;
  localparam logic [7:0] STEP_DISP  = 8'd1;
  localparam logic [7:0] WAKE_BYTE  = 8'h30;
  localparam logic [7:0] LINE1_BASE = 8'h80;
  localparam logic [7:0] LINE2_BASE = 8'hC0;
  localparam logic [7:0] GATE_MAX   = 8'hFF;
  localparam logic [FIFO_CW-1:0] FIFO_FULL = FIFO_CW'(FIFO_DEPTH);

  function automatic logic [FIFO_AW-1:0] fifo_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0] kind;
  logic [7:0] value;
  logic [1:0] line;
  logic       acc;

  logic [7:0]         init_cmd_r, init_cmd_nxt;
  logic [7:0]         disp_cmd_r, disp_cmd_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [7:0]         gate_r, gate_nxt;
  logic               cmd_mode_r, cmd_mode_nxt;
  logic [FIFO_AW-1:0] head_r, head_nxt;
  logic [FIFO_AW-1:0] tail_r, tail_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               pend_r, pend_nxt;
  logic [FIFO_AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]         pend_byte_r, pend_byte_nxt;
  logic               st_v_r;
  logic [JT_W-1:0]    st_type_r;
  logic [7:0]         st_byte_r;

  logic               is_cmd, is_chr, need_mark;
  logic [7:0]         byte_val;
  logic [FIFO_AW-1:0] tail1;
  logic [FIFO_CW-1:0] count1;
  logic [7:0]         gate_inc;
  logic               job_v;
  logic [JT_W-1:0]    job_type;
  logic [7:0]         job_byte;

  logic               ram_we, ram_re;
  logic [FIFO_AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign value = in_tdata[7:0];
  assign line  = in_tdata[9:8];
  assign kind  = in_tuser;

  // One slot in the job queue must be free for every job in flight.
  assign in_tready = !pend_r && ((jq_level + JQ_LW'(st_v_r)) < JQ_LW'(JQ_DEPTH));
  assign acc       = in_tvalid && in_tready;

  assign is_cmd = (kind == KIND_CMD) ||
                  ((kind == KIND_GOTO) && ((line == 2'd1) || (line == 2'd2)));
  assign is_chr = (kind == KIND_CHAR);
  assign need_mark = (is_cmd && !cmd_mode_r) || (is_chr && cmd_mode_r);
  assign gate_inc  = (gate_r == GATE_MAX) ? gate_r : gate_r + 8'd1;

  always_comb begin
    byte_val = value;
    if (kind == KIND_GOTO) begin
      byte_val = (line == 2'd1) ? value + LINE1_BASE : value + LINE2_BASE;
    end
  end

  always_comb begin
    init_cmd_nxt  = init_cmd_r;
    disp_cmd_nxt  = disp_cmd_r;
    cnt_nxt       = cnt_r;
    gate_nxt      = gate_r;
    cmd_mode_nxt  = cmd_mode_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_byte_nxt = pend_byte_r;
    tail1         = tail_r;
    count1        = count_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_wdata     = {1'b0, byte_val};
    ram_re        = 1'b0;
    job_v         = 1'b0;
    job_type      = JOB_CLR;
    job_byte      = WAKE_BYTE;

    // Second write of a mode switch: the byte behind its marker.
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = {1'b0, pend_byte_r};
    end

    if (acc) begin
      if (kind == KIND_TICK) begin
        gate_nxt = gate_inc;
        if (cnt_r != 8'd0) begin
          cnt_nxt = cnt_r - 8'd1;
          job_v   = 1'b1;
          case (cnt_r) inside
            STEP_WAKE: begin
              job_type = JOB_ONE;
              job_byte = WAKE_BYTE;
            end
            STEP_REP_A, STEP_REP_B: begin
              job_type = JOB_REPEAT;
            end
            STEP_FS1: begin
              job_type = JOB_ONE;
              job_byte = init_cmd_r;
            end
            STEP_FS2: begin
              job_type = JOB_TWO;
              job_byte = init_cmd_r;
            end
            STEP_DISP: begin
              job_type = JOB_TWO;
              job_byte = disp_cmd_r;
            end
            default: begin
              job_type = JOB_CLR;
            end
          endcase
        end else if ((count_r != '0) && (gate_inc == GATE_MAX)) begin
          job_v     = 1'b1;
          job_type  = JOB_DRAIN;
          ram_re    = 1'b1;
          head_nxt  = fifo_inc(head_r);
          count_nxt = count_r - 1'b1;
        end
      end else if (is_cmd || is_chr) begin
        if (need_mark) begin
          cmd_mode_nxt = is_cmd;
          if (count_r < FIFO_FULL) begin
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            ram_wdata = {1'b1, 7'd0, is_chr};
            tail1     = fifo_inc(tail_r);
            count1    = count_r + 1'b1;
          end
        end
        if (count1 < FIFO_FULL) begin
          if (need_mark) begin
            pend_nxt      = 1'b1;
            pend_addr_nxt = tail1;
            pend_byte_nxt = byte_val;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail1;
          end
          tail_nxt  = fifo_inc(tail1);
          count_nxt = count1 + 1'b1;
        end else begin
          tail_nxt  = tail1;
          count_nxt = count1;
        end
      end
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_INIT:  init_cmd_nxt = cfg_wdata;
        REG_DISP:  disp_cmd_nxt = cfg_wdata;
        REG_START: cnt_nxt      = cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cmd_r <= 8'd40;
      disp_cmd_r <= 8'd12;
      cnt_r      <= 8'd100;
      gate_r     <= 8'd0;
      cmd_mode_r <= 1'b1;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      pend_r     <= 1'b0;
      st_v_r     <= 1'b0;
    end else begin
      init_cmd_r <= init_cmd_nxt;
      disp_cmd_r <= disp_cmd_nxt;
      cnt_r      <= cnt_nxt;
      gate_r     <= gate_nxt;
      cmd_mode_r <= cmd_mode_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      st_v_r     <= acc && job_v;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_byte_r <= pend_byte_nxt;
    if (acc) begin
      st_type_r <= job_type;
      st_byte_r <= job_byte;
    end
  end

  lcdns_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(FIFO_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Drain jobs pick up the entry read at accept time.
  assign jq_push      = st_v_r;
  assign jq_job.jtype = st_type_r;
  assign jq_job.data  = (st_type_r == JOB_DRAIN) ? ram_rdata : {1'b0, st_byte_r};

  `LCDNS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= FIFO_FULL)
  `LCDNS_ASSERT_IMP(a_pend_blocks, pend_r, !in_tready && !ram_re)
  `LCDNS_ASSERT_NXT(a_pend_once, pend_r, !pend_r)
  `LCDNS_ASSERT_IMP(a_stage_room, st_v_r, jq_level < JQ_LW'(JQ_DEPTH))

endmodule

[hw/rtl/lcdns_jobq.sv]
// Small job queue between the front end and the nibble back end.
module lcdns_jobq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  lcdns_pkg::job_t             job_in,
  input  logic                        pop,
  output lcdns_pkg::job_t             head,
  output logic [lcdns_pkg::JQ_LW-1:0] level
);
  import lcdns_pkg::*;

  job_t             q_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wptr_r, rptr_r;
  logic [JQ_LW-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      level_r <= level_r + JQ_LW'(push) - JQ_LW'(pop);
    end
  end

  assign head  = q_r[rptr_r];
  assign level = level_r;

endmodule

[hw/rtl/lcdns_back.sv]
// Back end: turns jobs into enable-pulse words and holds rs and the port latch.
module lcdns_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcdns_pkg::job_t             head,
  input  logic [lcdns_pkg::JQ_LW-1:0] level,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [3:0]                  out_nibble,
  output logic                        out_rs,
  output logic                        out_last
);
  import lcdns_pkg::*;

  logic       out_v_r;
  logic [3:0] nib_r;
  logic       rs_r;
  logic       last_r;
  logic       phase_r, phase_nxt;
  logic       rs_latch_r, rs_latch_nxt;
  logic [3:0] port_r, port_nxt;

  logic       slot, hv, emit;
  logic [3:0] nib;
  logic       rs, last;

  assign slot = !out_v_r || out_tready;
  assign hv   = (level != '0);

  always_comb begin
    pop          = 1'b0;
    emit         = 1'b0;
    nib          = head.data[7:4];
    rs           = 1'b0;
    last         = 1'b0;
    phase_nxt    = phase_r;
    rs_latch_nxt = rs_latch_r;
    port_nxt     = port_r;
    if (hv) begin
      unique case (head.jtype) inside
        JOB_CLR: begin
          rs_latch_nxt = 1'b0;
          pop          = 1'b1;
        end
        JOB_ONE, JOB_REPEAT: begin
          if (slot) begin
            emit         = 1'b1;
            last         = 1'b1;
            pop          = 1'b1;
            rs_latch_nxt = 1'b0;
            if (head.jtype == JOB_REPEAT) begin
              nib = port_r;
            end
          end
        end
        JOB_TWO, JOB_DRAIN: begin
          if ((head.jtype == JOB_DRAIN) && head.data[8]) begin
            // marker: switch rs, no pulse
            rs_latch_nxt = head.data[0];
            pop          = 1'b1;
          end else if (slot) begin
            emit = 1'b1;
            rs   = (head.jtype == JOB_DRAIN) ? rs_latch_r : 1'b0;
            if (head.jtype == JOB_TWO) begin
              rs_latch_nxt = 1'b0;
            end
            if (phase_r) begin
              nib       = head.data[3:0];
              last      = 1'b1;
              pop       = 1'b1;
              phase_nxt = 1'b0;
            end else begin
              phase_nxt = 1'b1;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
    if (emit) begin
      port_nxt = nib;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      phase_r    <= 1'b0;
      rs_latch_r <= 1'b0;
      port_r     <= 4'd0;
    end else begin
      if (slot) begin
        out_v_r <= emit;
      end
      phase_r    <= phase_nxt;
      rs_latch_r <= rs_latch_nxt;
      port_r     <= port_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      nib_r  <= nib;
      rs_r   <= rs;
      last_r <= last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_nibble = nib_r;
  assign out_rs     = rs_r;
  assign out_last   = last_r;

endmodule

[bench/char_lcd_nibble_sequencer_test.sv]
// Self-checking bench for the character LCD nibble sequencer.
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_test;
  import lcdns_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  localparam logic [1:0] REG_NONE = 2'd3;     // no register behind this index
  localparam logic [1:0] LINE_1   = 2'd1;
  localparam logic [1:0] LINE_2   = 2'd2;
  localparam logic [7:0] GOTO_BASE    = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;
  localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
  localparam logic [ENTRY_W-1:0] MARK_CMD  = 9'h100;
  localparam logic [ENTRY_W-1:0] MARK_DATA = 9'h101;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } lcd_pulse_t;

  class lcd_pulse_board;
    logic [7:0]         init_cmd, disp_cmd;
    logic [7:0]         countdown, gate;
    logic               cmd_mode, rs_q;
    logic [3:0]         port_q;
    logic [ENTRY_W-1:0] entries [FIFO_DEPTH];
    int                 head, tail, fill;
    lcd_pulse_t         pulses_due [$];
    int                 errors;

    function new();
      init_cmd  = 8'd40;
      disp_cmd  = 8'd12;
      countdown = 8'd100;
      gate      = 8'd0;
      cmd_mode  = 1'b1;
      rs_q      = 1'b0;
      port_q    = 4'h0;
      head      = 0;
      tail      = 0;
      fill      = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [7:0] data);
      case (index)
        REG_INIT:  init_cmd = data;
        REG_DISP:  disp_cmd = data;
        REG_START: countdown = data;   // the write also restarts the startup sequence
        default: ;
      endcase
    endfunction

    // drop the entry when the queue is full
    function void push_entry(logic [ENTRY_W-1:0] e);
      if (fill < FIFO_DEPTH) begin
        entries[tail] = e;
        tail = (tail + 1) % FIFO_DEPTH;
        fill++;
      end
    endfunction

    function void queue_cmd(logic [7:0] b);
      if (!cmd_mode) begin
        push_entry(MARK_CMD);
        cmd_mode = 1'b1;
      end
      push_entry({1'b0, b});
    endfunction

    function void emit(logic [3:0] nib);
      port_q = nib;
      pulses_due.push_back('{rs: rs_q, nibble: nib, last: 1'b0});
    endfunction

    function void note_word(logic [1:0] kind, logic [7:0] value, logic [1:0] line);
      int                 n_prior;
      logic [ENTRY_W-1:0] e;
      n_prior = pulses_due.size();
      case (kind)
        KIND_CMD: queue_cmd(value);
        KIND_CHAR: begin
          if (cmd_mode) begin
            push_entry(MARK_DATA);
            cmd_mode = 1'b0;
          end
          push_entry({1'b0, value});
        end
        KIND_GOTO: begin
          if (line == LINE_1) queue_cmd(GOTO_BASE + value);
          else if (line == LINE_2) queue_cmd(GOTO_BASE + LINE2_OFFSET + value);
        end
        default: begin
          if (gate != 8'hFF) gate++;
          if (countdown != 8'd0) begin
            rs_q = 1'b0;
            // pulses come at fixed countdown values on the way down to zero
            case (countdown)
              8'd12:      emit(WAKE_NIBBLE);
              8'd5, 8'd4: emit(port_q);
              8'd3:       emit(init_cmd[7:4]);
              8'd2: begin
                emit(init_cmd[7:4]);
                emit(init_cmd[3:0]);
              end
              8'd1: begin
                emit(disp_cmd[7:4]);
                emit(disp_cmd[3:0]);
              end
              default: ;
            endcase
            countdown--;
          end else if (fill > 0 && gate == 8'hFF) begin
            e = entries[head];
            head = (head + 1) % FIFO_DEPTH;
            fill--;
            if (e[ENTRY_W-1]) rs_q = e[0];
            else begin
              emit(e[7:4]);
              emit(e[3:0]);
            end
          end
          if (pulses_due.size() > n_prior) pulses_due[pulses_due.size()-1].last = 1'b1;
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_pulse(logic rs, logic [7:0] data, logic last);
      lcd_pulse_t want;
      if (pulses_due.size() == 0) begin
        report($sformatf("output word rs=%b data=%h last=%b with none expected", rs, data, last));
        return;
      end
      want = pulses_due.pop_front();
      if (rs !== want.rs) report($sformatf("rs %b, expected %b", rs, want.rs));
      if (data !== {4'h0, want.nibble})
        report($sformatf("data %h, expected nibble %h", data, want.nibble));
      if (last !== want.last) report($sformatf("last %b, expected %b", last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  int src_idle_pct = 21;
  int snk_idle_pct = 81;
  int hold_request = 0;

  lcd_pulse_board sb = new();

  char_lcd_nibble_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: check each accepted word, throttle tready, serve long hold-offs.
  initial begin : sink
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_pulse(out_tuser, out_tdata, out_tlast);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        out_tready <= 1'b0;
        held--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_word(logic [1:0] kind, logic [7:0] value, logic [1:0] line);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, line, value};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(kind, value, line);
  endtask

  task automatic send_random(int count, int tick_pct);
    logic [1:0] kind;
    repeat (count) begin
      if ($urandom_range(0, 99) < tick_pct) kind = KIND_TICK;
      else kind = 2'($urandom_range(1, 3));
      send_word(kind, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pulses_due.size() != 0) @(posedge clk);
  endtask

  // Hold the input until every pulse is out, then let queued-only words finish.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] index, logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(index, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of each kind, every goto line, mode switches both ways
    send_word(KIND_CMD,  8'h00, 2'd0);
    send_word(KIND_CMD,  8'hFF, 2'd3);
    send_word(KIND_CHAR, 8'h00, 2'd0);
    send_word(KIND_CHAR, 8'hFF, 2'd3);
    send_word(KIND_GOTO, 8'h12, 2'd0);
    send_word(KIND_GOTO, 8'h00, LINE_1);
    send_word(KIND_GOTO, 8'hFF, LINE_1);
    send_word(KIND_CHAR, 8'h5A, 2'd1);
    send_word(KIND_GOTO, 8'h00, LINE_2);
    send_word(KIND_GOTO, 8'hFF, LINE_2);
    send_word(KIND_GOTO, 8'h34, 2'd3);
    send_word(KIND_CHAR, 8'hA5, 2'd2);
    // overflow the queue while the gate is closed; markers get dropped too
    for (int i = 0; i < 10; i++)
      send_word(i[0] ? KIND_CHAR : KIND_CMD, 8'($urandom_range(0, 255)),
                2'($urandom_range(0, 3)));
    // run out the default startup and open the drain gate
    repeat (256) send_word(KIND_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    send_random(20, 50);

    settle();
    cfg_write(REG_INIT, 8'hFF);
    cfg_write(REG_DISP, 8'h00);
    cfg_write(REG_START, 8'd13);
    cfg_write(REG_NONE, 8'($urandom_range(0, 255)));
    src_idle_pct = 81;
    snk_idle_pct = 21;
    send_random(24, 70);

    settle();
    cfg_write(REG_INIT, 8'($urandom_range(0, 255)));
    cfg_write(REG_DISP, 8'($urandom_range(0, 255)));
    cfg_write(REG_START, 8'($urandom_range(13, 30)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // queue 20 characters, then keep ticking into a stalled receiver
    repeat (20) send_word(KIND_CHAR, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    hold_request = HOLD_CYCLES;
    repeat (50) send_word(KIND_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    wait_drained();
    send_random(10, 50);

    settle();
    cfg_write(REG_INIT, 8'h00);
    cfg_write(REG_DISP, 8'hFF);
    cfg_write(REG_START, 8'd16);
    send_random(24, 90);

    settle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_ram.sv
hw/rtl/lcdns_front.sv
hw/rtl/lcdns_jobq.sv
hw/rtl/lcdns_back.sv
hw/rtl/char_lcd_nibble_sequencer.sv
bench/char_lcd_nibble_sequencer_test.sv
